// ----- src/ppmd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppmd_pkg
// shared constants, register indexes and control structs of the ppm decoder
// ----------------------------------------------------------------------------
package ppmd_pkg;

  // geometry
  localparam int MAX_DIMENSION = 4096;
  localparam int COORD_W       = 12;
  localparam int DIM_W         = COORD_W + 1;

  // sample arithmetic
  localparam int ACC_W     = 16;
  localparam int PROD_W    = ACC_W + 8;
  localparam int SAMPLE_W  = 8;
  localparam int CHAN_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [CHAN_W-1:0]   LAST_CHAN  = 2'd2;
  localparam logic [ACC_W-1:0]    ACC_LIMIT  = 16'hFFFF;
  localparam logic [7:0]          CHAR_ZERO  = 8'h30;
  localparam logic [7:0]          CHAR_NINE  = 8'h39;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic mul;       // form value * 255 and latch divisor
    logic chk;       // range check, seed remainder
    logic div_step;  // one restoring division step
    logic emit;      // load output register, advance position
  } ppmd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_sample;  // accepted word completes a sample
    logic out_free;      // output register can take a word this cycle
  } ppmd_sts_t;

  // clamp a dimension register to 1..MAX_DIMENSION
  function automatic logic [DIM_W-1:0] bound_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/ppmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppmd_ctrl
// sequencer: accept, multiply, range check, eight divide steps, emit
// ----------------------------------------------------------------------------
module ppmd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppmd_pkg::ppmd_sts_t sts,
  output ppmd_pkg::ppmd_cmd_t cmd
);
  import ppmd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.start_sample) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = ST_DIV;
        step_nxt  = '0;
      end
      ST_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign cmd.accept   = (state_r == ST_IDLE) && in_valid;
  assign cmd.mul      = (state_r == ST_MUL);
  assign cmd.chk      = (state_r == ST_CHK);
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.emit     = (state_r == ST_EMIT) && sts.out_free;

endmodule

// ----- src/ppmd_dp.sv -----
// ----------------------------------------------------------------------------
// ppmd_dp
// config registers, digit accumulator, scaler, position counters, output reg
// ----------------------------------------------------------------------------
module ppmd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ppmd_pkg::ppmd_cmd_t                 cmd,
  output ppmd_pkg::ppmd_sts_t                 sts,
  input  logic [7:0]                          in_byte,
  input  logic                                cfg_we,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppmd_pkg::CFG_DAT_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ppmd_pkg::SAMPLE_W-1:0]       out_sample,
  output logic [ppmd_pkg::CHAN_W-1:0]         out_channel,
  output logic [ppmd_pkg::COORD_W-1:0]        out_column,
  output logic [ppmd_pkg::COORD_W-1:0]        out_row,
  output logic                                out_over_range,
  output logic                                out_last
);
  import ppmd_pkg::*;

  // configuration
  logic                 binary_mode_r;
  logic [DIM_W-1:0]     image_width_r;
  logic [DIM_W-1:0]     image_height_r;
  logic [ACC_W-1:0]     max_level_r;

  // parse and position state
  logic [ACC_W-1:0]     acc_r;
  logic                 pending_r;
  logic [CHAN_W-1:0]    chan_r;
  logic [COORD_W-1:0]   col_r;
  logic [COORD_W-1:0]   row_r;
  logic                 done_r;

  // scaler
  logic [ACC_W-1:0]     value_r;
  logic [PROD_W-1:0]    prod_r;
  logic [ACC_W-1:0]     divisor_r;
  logic [ACC_W-1:0]     rem_r;
  logic [SAMPLE_W-1:0]  low_r;
  logic [SAMPLE_W-1:0]  quot_r;
  logic                 over_r;

  // output register
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_sample_r;
  logic [CHAN_W-1:0]    out_channel_r;
  logic [COORD_W-1:0]   out_column_r;
  logic [COORD_W-1:0]   out_row_r;
  logic                 out_over_r;
  logic                 out_last_r;

  logic                 is_digit;
  logic [ACC_W+3:0]     acc_mul;
  logic [ACC_W-1:0]     acc_nxt;
  logic [ACC_W:0]       trial;
  logic                 fits;
  logic [DIM_W-1:0]     w_bound, h_bound;
  logic                 row_end, img_end, is_blue;

  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign acc_mul  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                  + (ACC_W+4)'(in_byte - CHAR_ZERO);
  assign acc_nxt  = (acc_mul > (ACC_W+4)'(ACC_LIMIT)) ? ACC_LIMIT : acc_mul[ACC_W-1:0];

  assign sts.start_sample = !done_r && (binary_mode_r || (!is_digit && pending_r));
  assign sts.out_free     = !out_valid_r || !out_stall;

  // restoring divide step
  assign trial = {rem_r, low_r[SAMPLE_W-1]};
  assign fits  = trial >= {1'b0, divisor_r};

  assign w_bound = bound_dim(image_width_r);
  assign h_bound = bound_dim(image_height_r);
  assign row_end = ({1'b0, col_r} + DIM_W'(1)) >= w_bound;
  assign img_end = row_end && (({1'b0, row_r} + DIM_W'(1)) >= h_bound);
  assign is_blue = (chan_r >= LAST_CHAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r  <= 1'b0;
      image_width_r  <= DIM_W'(1);
      image_height_r <= DIM_W'(1);
      max_level_r    <= ACC_W'(255);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BINARY_MODE:  binary_mode_r  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_W-1:0];
        REG_MAX_LEVEL:    max_level_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte parsing and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pending_r <= 1'b0;
      chan_r    <= '0;
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
    end else begin
      if (cmd.accept && !done_r && !binary_mode_r) begin
        if (is_digit) begin
          acc_r     <= acc_nxt;
          pending_r <= 1'b1;
        end else if (pending_r) begin
          acc_r     <= '0;
          pending_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        if (is_blue) begin
          chan_r <= '0;
          if (row_end) begin
            col_r <= '0;
            if (img_end) begin
              done_r <= 1'b1;
            end else begin
              row_r <= row_r + COORD_W'(1);
            end
          end else begin
            col_r <= col_r + COORD_W'(1);
          end
        end else begin
          chan_r <= chan_r + CHAN_W'(1);
        end
      end
    end
  end

  // scaler: value * 255 / max_level, eight quotient bits
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r <= binary_mode_r ? {8'b0, in_byte} : acc_r;
    end
    if (cmd.mul) begin
      prod_r    <= ({8'b0, value_r} << 8) - {8'b0, value_r};
      divisor_r <= (max_level_r == '0) ? ACC_W'(1) : max_level_r;
    end
    if (cmd.chk) begin
      over_r <= prod_r >= {divisor_r, 8'b0};
      rem_r  <= prod_r[PROD_W-1:SAMPLE_W];
      low_r  <= prod_r[SAMPLE_W-1:0];
      quot_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= fits ? (trial[ACC_W-1:0] - divisor_r) : trial[ACC_W-1:0];
      low_r  <= {low_r[SAMPLE_W-2:0], 1'b0};
      quot_r <= {quot_r[SAMPLE_W-2:0], fits};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r  <= over_r ? FULL_SCALE : quot_r;
      out_channel_r <= chan_r;
      out_column_r  <= col_r;
      out_row_r     <= row_r;
      out_over_r    <= over_r;
      out_last_r    <= is_blue && img_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_channel    = out_channel_r;
  assign out_column     = out_column_r;
  assign out_row        = out_row_r;
  assign out_over_range = out_over_r;
  assign out_last       = out_last_r;

endmodule

// ----- src/ppm_pixel_body_decoder.sv -----
// ----------------------------------------------------------------------------
// ppm_pixel_body_decoder
// turns ppm pixel-body bytes (text or raw) into scaled rgb samples with position
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  in_byte, one body byte
//   out_     output     out_valid/out_stall  sample, channel, column, row,
//                                            over_range, last
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a digit or an ignored byte is taken and the block stays idle; a byte that
// completes a sample runs accept, multiply, range check, 8 restoring divide
// steps, then a load that waits while the full output register is stalled
// the next byte is taken while a finished word still waits on out_stall
// rst_n is synchronous and active low; config regs reset to 0, 1, 1, 255
// cfg_ready is always high; write config only while the block is idle
//
module ppm_pixel_body_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  // sample output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppmd_pkg::SAMPLE_W-1:0]   out_sample,
  output logic [ppmd_pkg::CHAN_W-1:0]     out_channel,
  output logic [ppmd_pkg::COORD_W-1:0]    out_column,
  output logic [ppmd_pkg::COORD_W-1:0]    out_row,
  output logic                            out_over_range,
  output logic                            out_last,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmd_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import ppmd_pkg::*;

  ppmd_cmd_t cmd;
  ppmd_sts_t sts;
  logic      cfg_we;

  // registers can be written any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer
  ppmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parsing, scaling, position tracking and output register
  ppmd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte        (in_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_channel    (out_channel),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_over_range (out_over_range),
    .out_last       (out_last)
  );

endmodule
